>>> rtl/lru_kvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, constants and the command/status bundles that pass between
// the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_kvc_pkg;

    localparam int DATA_W   = 32;
    localparam int CAP_W    = 5;
    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 72;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // At most one operation per cycle is issued by the sequencer; none while it waits in idle or on a busy output.
    typedef struct packed {
        logic capture;
        logic match;
        logic touch;
        logic evict;
        logic insert;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic hit_now;
        logic is_put;
        logic full;
        logic over_cap;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/lru_kvc_dp.sv
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Key compare lanes, recency ranks, value memory, capacity register and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_kvc_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lru_kvc_pkg::t_cmd                i_cmd,
    output lru_kvc_pkg::t_status                  o_status,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [lru_kvc_pkg::CAP_W-1:0]    i_cfg_wr_data,
    input  wire logic                             i_in_op,
    input  wire logic [lru_kvc_pkg::DATA_W-1:0]   i_in_key,
    input  wire logic [lru_kvc_pkg::DATA_W-1:0]   i_in_value,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [lru_kvc_pkg::M_DATA_W-1:0]      o_out_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lru_kvc_pkg::CAP_W) ? CNT_W : lru_kvc_pkg::CAP_W;
    localparam int DW    = lru_kvc_pkg::DATA_W;
    localparam int PAD_W = lru_kvc_pkg::M_DATA_W - (2 * DW + 2);

    // Entry lanes and occupancy.
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [DW-1:0]          r_key [MAX_ENTRIES];
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_occ;
    logic [DW-1:0]          r_val_mem [MAX_ENTRIES];
    logic [DW-1:0]          r_rd_data;

    logic [lru_kvc_pkg::CAP_W-1:0] r_capacity;

    // Captured transaction and per-operation results.
    logic                   r_in_op;
    logic [DW-1:0]          r_in_key;
    logic [DW-1:0]          r_in_value;
    logic                   r_hit;
    logic [MAX_ENTRIES-1:0] r_hit_oh;
    logic [IDX_W-1:0]       r_hit_idx;
    logic                   r_ev;
    logic [DW-1:0]          r_ev_key;

    logic                        r_out_valid;
    logic [lru_kvc_pkg::M_DATA_W-1:0] r_out_data;

    logic [MAX_ENTRIES-1:0] match_vec;
    logic [IDX_W-1:0]       match_idx;
    logic [MAX_ENTRIES-1:0] oldest_vec;
    logic [MAX_ENTRIES-1:0] victim_oh;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       touch_rank;
    logic [DW-1:0]          victim_key;
    logic [CNT_W-1:0]       occ_dec;
    logic [DW-1:0]          read_value;

    always_comb begin
        match_idx  = '0;
        free_idx   = '0;
        touch_rank = '0;
        victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_vec[i]  = r_valid[i] && (r_key[i] == r_in_key);
            oldest_vec[i] = r_valid[i] && (r_rank[i] == '0);
        end
        // Isolate the lowest set bit of each candidate vector.
        victim_oh = oldest_vec & (~oldest_vec + MAX_ENTRIES'(1));
        free_oh   = ~r_valid & (r_valid + MAX_ENTRIES'(1));
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_vec[i]) begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_oh[i]) begin
                free_idx = free_idx | IDX_W'(i);
            end
            if (r_hit_oh[i]) begin
                touch_rank = touch_rank | r_rank[i];
            end
            if (victim_oh[i]) begin
                victim_key = victim_key | r_key[i];
            end
        end
    end

    assign occ_dec = r_occ - 1'b1;

    // Ranks, valid bits and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cmd.touch) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (r_valid[i] && (r_rank[i] > touch_rank)) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
                r_rank[r_hit_idx] <= occ_dec[IDX_W-1:0];
            end
            if (i_cmd.evict && (|victim_oh)) begin
                r_valid <= r_valid & ~victim_oh;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (victim_oh[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] != '0)) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
                r_occ <= occ_dec;
            end
            if (i_cmd.insert && (|free_oh)) begin
                r_valid          <= r_valid | free_oh;
                r_rank[free_idx] <= r_occ[IDX_W-1:0];
                r_occ            <= r_occ + 1'b1;
            end
        end
    end

    // Keys are written only into a free lane.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i_cmd.insert && free_oh[i]) begin
                r_key[i] <= r_in_key;
            end
        end
    end

    // Value memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.touch && (r_in_op == lru_kvc_pkg::OP_PUT)) begin
            r_val_mem[r_hit_idx] <= r_in_value;
        end else if (i_cmd.insert && (|free_oh)) begin
            r_val_mem[free_idx] <= r_in_value;
        end
        r_rd_data <= r_val_mem[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lru_kvc_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op    <= i_in_op;
            r_in_key   <= i_in_key;
            r_in_value <= i_in_value;
        end
        if (i_cmd.match) begin
            r_hit     <= |match_vec;
            r_hit_oh  <= match_vec;
            r_hit_idx <= match_idx;
            r_ev      <= 1'b0;
            r_ev_key  <= '0;
        end
        if (i_cmd.evict) begin
            r_ev     <= 1'b1;
            r_ev_key <= victim_key;
        end
    end

    always_comb begin
        if (r_in_op == lru_kvc_pkg::OP_PUT) begin
            read_value = '0;
        end else if (r_hit) begin
            read_value = r_rd_data;
        end else begin
            read_value = lru_kvc_pkg::MISS_VALUE;
        end
    end

    // Result register; a new result may load in the cycle the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {PAD_W'(0), r_ev_key, r_ev, read_value, r_hit};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.hit_now  = |match_vec;
    assign o_status.is_put   = (r_in_op == lru_kvc_pkg::OP_PUT);
    assign o_status.full     = (r_occ == CNT_W'(MAX_ENTRIES));
    assign o_status.over_cap = !r_ev && (CMP_W'(r_occ) > CMP_W'(r_capacity));
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> rtl/lru_kvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key/value cache sequencer
// Steps one transaction through lookup, refresh, insert and eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_kvc_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire lru_kvc_pkg::t_status    i_status,
    output lru_kvc_pkg::t_cmd            o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_MATCH      = 8'b0000_0010,
        S_TOUCH      = 8'b0000_0100,
        S_EVICT_PRE  = 8'b0000_1000,
        S_INSERT     = 8'b0001_0000,
        S_CHECK      = 8'b0010_0000,
        S_EVICT_POST = 8'b0100_0000,
        S_RESP       = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                if (i_status.hit_now) begin
                    n_state = S_TOUCH;
                end else if (!i_status.is_put) begin
                    n_state = S_RESP;
                end else if (i_status.full) begin
                    n_state = S_EVICT_PRE;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_TOUCH: begin
                o_cmd.touch = 1'b1;
                n_state     = i_status.is_put ? S_CHECK : S_RESP;
            end
            S_EVICT_PRE: begin
                // A full store frees its oldest lane before the new key lands.
                o_cmd.evict = 1'b1;
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.over_cap ? S_EVICT_POST : S_RESP;
            end
            S_EVICT_POST: begin
                o_cmd.evict = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each transaction is a get (tuser 0) or a put (tuser 1) on a 32-bit key and
// produces exactly one result. A sequencer steps one operation per clock
// through the datapath: a get miss passes through capture, match and
// response; a get hit adds a refresh; a put of a present key refreshes and
// then checks capacity; a put of a new key inserts and checks capacity; and a
// put that evicts does so before the insert (full store) or after the check
// (over capacity). The next transaction is accepted in the cycle after the
// load of the result register, while the previous result may still wait on
// the output. If that earlier result has not left by the load cycle, the
// sequencer holds in its last step until the output register frees up. Key
// compare runs over all lanes at once; values live in a memory with a
// registered read. The capacity register may be written only while the block
// is idle; values above MAX_ENTRIES act as MAX_ENTRIES, and lowering it below
// the occupancy evicts one entry per later put.
`default_nettype none

module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lru_kvc_pkg::CAP_W-1:0]       i_cfg_wr_data,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [31:0] lookup_key, [63:32] store_value
    input  wire logic [lru_kvc_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // [0] opcode
    input  wire logic [lru_kvc_pkg::S_USER_W-1:0]    i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key, [71:66] zero
    output logic [lru_kvc_pkg::M_DATA_W-1:0]         o_m_axis_tdata
);

    lru_kvc_pkg::t_cmd    cmd;
    lru_kvc_pkg::t_status status;

    lru_kvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lru_kvc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_op       (i_s_axis_tuser[0]),
        .i_in_key      (i_s_axis_tdata[31:0]),
        .i_in_value    (i_s_axis_tdata[63:32]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_data    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
